// ----- design/grid_line_of_sight_check_top_assert.svh -----
// Assertion macros used by the line-of-sight design file.
`ifndef GRID_LINE_OF_SIGHT_CHECK_TOP_ASSERT_SVH
`define GRID_LINE_OF_SIGHT_CHECK_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gls: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gls: assertion failed");

`endif

// ----- design/gls_pkg.sv -----
`default_nettype none

package gls_pkg;

  localparam int COORD_W         = 6;
  localparam int DIM_W           = 9;
  localparam int ERR_W           = COORD_W + 3;
  localparam int GRID_WIDTH_DEF  = 64;
  localparam int GRID_HEIGHT_DEF = 64;

  localparam int S_TDATA_W = 40;
  localparam int S_TUSER_W = 1;
  localparam int M_TDATA_W = 8;

  localparam int CELL_X_LSB  = 0;
  localparam int CELL_Y_LSB  = CELL_X_LSB + COORD_W;
  localparam int CELL_BLK_B  = CELL_Y_LSB + COORD_W;
  localparam int FROM_X_LSB  = CELL_BLK_B + 1;
  localparam int FROM_Y_LSB  = FROM_X_LSB + COORD_W;
  localparam int TO_X_LSB    = FROM_Y_LSB + COORD_W;
  localparam int TO_Y_LSB    = TO_X_LSB + COORD_W;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [2:0] {
    GLS_CLEAR,
    GLS_IDLE,
    GLS_SETUP,
    GLS_WALK,
    GLS_DONE
  } gls_state_e;

endpackage

`default_nettype wire

// ----- design/grid_line_of_sight_check_top.sv -----
// Grid line-of-sight checker. A beat with tuser low writes one map cell (no result);
// a beat with tuser high asks whether the Bresenham line between two cells crosses an
// occupied cell and returns one result beat. After reset the block clears all
// GRID_WIDTH*GRID_HEIGHT map cells (4096 by default) with s_axis_tready low. A query
// walks the line along its major axis until it reaches the far endpoint or an occupied
// cell, and then waits while the previous result has not yet been taken. The map
// sits in one memory with one read port, and the walk reads one cell per cycle.
// A finished result waits in the output register while the next beat is taken.
`default_nettype none

`include "grid_line_of_sight_check_top_assert.svh"

module grid_line_of_sight_check_top
  import gls_pkg::*;
#(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // cell_x, cell_y, cell_blocked, from_x, from_y, to_x, to_y, zero padding
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  // action
  input  wire logic [S_TUSER_W-1:0] s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // blocked, zero padding
  output logic [M_TDATA_W-1:0]      m_axis_tdata
);

  localparam int DEPTH  = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  gls_state_e state_q, state_d;

  logic [ADDR_W-1:0]  clr_cnt_q, clr_cnt_d;
  logic [COORD_W-1:0] fx_q, fy_q, tx_q, ty_q;
  logic [COORD_W-1:0] fx_d, fy_d, tx_d, ty_d;
  logic [COORD_W-1:0] x_q, y_q, bx_q, dx_q, dy_q;
  logic [COORD_W-1:0] x_d, y_d, bx_d, dx_d, dy_d;
  logic [ERR_W-1:0]   err_q, err_d;
  logic               steep_q, steep_d;
  logic               yneg_q, yneg_d;
  logic               first_q, first_d;
  logic               chk_q, chk_d;
  logic               res_q, res_d;
  logic               m_valid_q, m_valid_d;
  logic               blk_q, blk_d;

  logic               mem_q [DEPTH];
  logic               rd_data_q;
  logic               mem_we, mem_wdata, mem_re;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;

  logic               s_acc;
  logic               act;
  logic [COORD_W-1:0] in_cx, in_cy;
  logic               in_cb;
  logic               wr_in_grid;

  logic [COORD_W-1:0] adx, ady, pax, pay, pbx, pby, sax, say, sbx, sby;
  logic               s_steep, s_swap;

  logic [COORD_W-1:0] col, row;
  logic               in_grid, hit, walk_end, out_free;
  logic [ERR_W-1:0]   err_sub, err_add;

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign act   = s_axis_tuser[0];
  assign in_cx = s_axis_tdata[CELL_X_LSB +: COORD_W];
  assign in_cy = s_axis_tdata[CELL_Y_LSB +: COORD_W];
  assign in_cb = s_axis_tdata[CELL_BLK_B];
  assign wr_in_grid = (DIM_W'(in_cx) < DIM_W'(GRID_WIDTH)) &&
                      (DIM_W'(in_cy) < DIM_W'(GRID_HEIGHT));

  // Set-up: choose the major axis, then order the endpoints along it.
  always_comb begin
    adx     = (fx_q > tx_q) ? fx_q - tx_q : tx_q - fx_q;
    ady     = (fy_q > ty_q) ? fy_q - ty_q : ty_q - fy_q;
    s_steep = ady > adx;
    pax     = s_steep ? fy_q : fx_q;
    pay     = s_steep ? fx_q : fy_q;
    pbx     = s_steep ? ty_q : tx_q;
    pby     = s_steep ? tx_q : ty_q;
    s_swap  = pax > pbx;
    sax     = s_swap ? pbx : pax;
    say     = s_swap ? pby : pay;
    sbx     = s_swap ? pax : pbx;
    sby     = s_swap ? pay : pby;
  end

  assign col      = steep_q ? y_q : x_q;
  assign row      = steep_q ? x_q : y_q;
  assign in_grid  = (DIM_W'(col) < DIM_W'(GRID_WIDTH)) &&
                    (DIM_W'(row) < DIM_W'(GRID_HEIGHT));
  assign hit      = chk_q && rd_data_q;
  assign walk_end = hit || (x_q == bx_q);
  assign err_sub  = err_q - ERR_W'({dy_q, 1'b0});
  assign err_add  = err_sub + ERR_W'({dx_q, 1'b0});
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      GLS_CLEAR: begin
        if (clr_cnt_q == ADDR_W'(DEPTH - 1)) state_d = GLS_IDLE;
      end
      GLS_IDLE: begin
        if (s_acc && act == ACT_QUERY) state_d = GLS_SETUP;
      end
      GLS_SETUP: state_d = GLS_WALK;
      GLS_WALK: begin
        if (walk_end) state_d = GLS_DONE;
      end
      GLS_DONE: begin
        if (out_free) state_d = GLS_IDLE;
      end
      default: state_d = GLS_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == GLS_IDLE);
    clr_cnt_d     = clr_cnt_q;
    fx_d          = fx_q;
    fy_d          = fy_q;
    tx_d          = tx_q;
    ty_d          = ty_q;
    x_d           = x_q;
    y_d           = y_q;
    bx_d          = bx_q;
    dx_d          = dx_q;
    dy_d          = dy_q;
    err_d         = err_q;
    steep_d       = steep_q;
    yneg_d        = yneg_q;
    first_d       = first_q;
    chk_d         = 1'b0;
    res_d         = res_q;
    m_valid_d     = m_valid_q && !m_axis_tready;
    blk_d         = blk_q;
    mem_we        = 1'b0;
    mem_waddr     = ADDR_W'(in_cy) * ADDR_W'(GRID_WIDTH) + ADDR_W'(in_cx);
    mem_wdata     = in_cb;
    mem_re        = 1'b0;
    mem_raddr     = ADDR_W'(row) * ADDR_W'(GRID_WIDTH) + ADDR_W'(col);
    case (state_q)
      GLS_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = 1'b0;
        clr_cnt_d = clr_cnt_q + ADDR_W'(1);
      end
      GLS_IDLE: begin
        if (s_acc) begin
          mem_we = (act == ACT_WRITE) && wr_in_grid;
          fx_d   = s_axis_tdata[FROM_X_LSB +: COORD_W];
          fy_d   = s_axis_tdata[FROM_Y_LSB +: COORD_W];
          tx_d   = s_axis_tdata[TO_X_LSB +: COORD_W];
          ty_d   = s_axis_tdata[TO_Y_LSB +: COORD_W];
        end
      end
      GLS_SETUP: begin
        x_d     = sax;
        y_d     = say;
        bx_d    = sbx;
        dx_d    = sbx - sax;
        dy_d    = (sby > say) ? sby - say : say - sby;
        err_d   = ERR_W'(sbx - sax);
        steep_d = s_steep;
        yneg_d  = !(say < sby);
        first_d = 1'b1;
      end
      GLS_WALK: begin
        if (walk_end) begin
          res_d = hit;
        end else begin
          chk_d   = !first_q && in_grid;
          mem_re  = chk_d;
          first_d = 1'b0;
          x_d     = x_q + COORD_W'(1);
          if (err_sub[ERR_W-1]) begin
            err_d = err_add;
            y_d   = yneg_q ? y_q - COORD_W'(1) : y_q + COORD_W'(1);
          end else begin
            err_d = err_sub;
          end
        end
      end
      GLS_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          blk_d     = res_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= GLS_CLEAR;
      clr_cnt_q <= '0;
      chk_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      chk_q     <= chk_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fx_q    <= fx_d;
    fy_q    <= fy_d;
    tx_q    <= tx_d;
    ty_q    <= ty_d;
    x_q     <= x_d;
    y_q     <= y_d;
    bx_q    <= bx_d;
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    err_q   <= err_d;
    steep_q <= steep_d;
    yneg_q  <= yneg_d;
    first_q <= first_d;
    res_q   <= res_d;
    blk_q   <= blk_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W-1){1'b0}}, blk_q};

  `GLS_ASSERT_NOW(a_walk_bound, clk_i, rst_ni, state_q == GLS_WALK, x_q <= bx_q)
  `GLS_ASSERT_NOW(a_chk_in_walk, clk_i, rst_ni, chk_q, state_q == GLS_WALK)
  `GLS_ASSERT_NOW(a_err_range, clk_i, rst_ni, state_q == GLS_WALK, !err_q[ERR_W-1] && (err_q <= ERR_W'({dx_q, 1'b0})))
  `GLS_ASSERT_NOW(a_result_from_done, clk_i, rst_ni, $rose(m_valid_q), $past(state_q) == GLS_DONE)

endmodule

`default_nettype wire

// ----- tb/tb_grid_line_of_sight_check_top.sv -----
`timescale 1ns / 1ps

module tb_grid_line_of_sight_check_top;
  import gls_pkg::*;

  localparam int GRID_CELLS = GRID_WIDTH_DEF * GRID_HEIGHT_DEF;
  localparam int COORD_MAX  = (1 << COORD_W) - 1;
  localparam int RANDOM_BEATS = 2000;
  localparam int IDLE_PCT    = 37;
  localparam int QUIET_FROM  = 1000;
  localparam int QUIET_TO    = 1300;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 100;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct {
    logic   action;
    coord_t cell_x;
    coord_t cell_y;
    logic   cell_blocked;
    coord_t from_x;
    coord_t from_y;
    coord_t to_x;
    coord_t to_y;
    bit     wait_idle;
  } los_beat_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // cell_x, cell_y, cell_blocked, from_x, from_y, to_x, to_y, zero padding
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  // action
  logic [S_TUSER_W-1:0] s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // blocked, zero padding
  logic [M_TDATA_W-1:0] m_axis_tdata;

  los_beat_t beat_q[$];
  bit        blocked_exp_q[$];
  bit        occ_map [0:GRID_CELLS-1];
  int        in_count = 0;
  int        err_count = 0;
  bit        s_took = 1'b0;
  bit        hold_done = 1'b0;
  int        hold_left = 0;

  grid_line_of_sight_check_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("tb_grid_line_of_sight_check_top failed");
    $finish;
  end

  function automatic bit cell_occupied(int col, int row);
    if (col < 0 || row < 0 || col >= GRID_WIDTH_DEF || row >= GRID_HEIGHT_DEF) begin
      return 1'b0;
    end
    return occ_map[row * GRID_WIDTH_DEF + col];
  endfunction

  // Integer Bresenham walk with the error term held at twice its natural scale.
  function automatic bit los_blocked(int ax, int ay, int bx, int by);
    int  t;
    int  dx;
    int  dy;
    int  err;
    int  ystep;
    int  y;
    bit  steep;
    bit  occ;
    steep = ((by > ay) ? by - ay : ay - by) > ((bx > ax) ? bx - ax : ax - bx);
    if (steep) begin
      t = ax; ax = ay; ay = t;
      t = bx; bx = by; by = t;
    end
    if (ax > bx) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
    end
    dx = bx - ax;
    dy = (by > ay) ? by - ay : ay - by;
    err = dx;
    ystep = (ay < by) ? 1 : -1;
    y = ay;
    for (int x = ax; x < bx; x++) begin
      if (!(x == ax && y == ay)) begin
        occ = steep ? cell_occupied(y, x) : cell_occupied(x, y);
        if (occ) begin
          return 1'b1;
        end
      end
      err -= 2 * dy;
      if (err < 0) begin
        y += ystep;
        err += 2 * dx;
      end
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("%0t: %s", $time, msg);
  endtask

  task automatic add_write(input int x, input int y, input bit blk, input bit hold = 1'b0);
    los_beat_t b;
    b.action       = ACT_WRITE;
    b.cell_x       = coord_t'(x);
    b.cell_y       = coord_t'(y);
    b.cell_blocked = blk;
    b.from_x       = coord_t'($urandom);
    b.from_y       = coord_t'($urandom);
    b.to_x         = coord_t'($urandom);
    b.to_y         = coord_t'($urandom);
    b.wait_idle    = hold;
    beat_q.push_back(b);
  endtask

  task automatic add_query(input int fx, input int fy, input int tx, input int ty,
                           input bit hold = 1'b0);
    los_beat_t b;
    b.action       = ACT_QUERY;
    b.cell_x       = coord_t'($urandom);
    b.cell_y       = coord_t'($urandom);
    b.cell_blocked = 1'($urandom_range(1));
    b.from_x       = coord_t'(fx);
    b.from_y       = coord_t'(fy);
    b.to_x         = coord_t'(tx);
    b.to_y         = coord_t'(ty);
    b.wait_idle    = hold;
    beat_q.push_back(b);
  endtask

  function automatic int near_coord(int c, int span);
    int v;
    v = c + int'($urandom_range(2 * span)) - span;
    if (v < 0) begin
      v = 0;
    end else if (v > COORD_MAX) begin
      v = COORD_MAX;
    end
    return v;
  endfunction

  // Results are checked before the new beat is predicted, so a result always pairs
  // with a query taken at an earlier edge.
  always @(posedge clk_i) begin : los_checker
    bit                   want;
    logic [M_TDATA_W-1:0] want_data;
    s_took <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (blocked_exp_q.size() == 0) begin
        report_mismatch($sformatf("result beat 0x%0h with no query outstanding",
                                  m_axis_tdata));
      end else begin
        want = blocked_exp_q.pop_front();
        want_data = M_TDATA_W'(want);
        if (m_axis_tdata !== want_data) begin
          report_mismatch($sformatf("blocked: got 0x%0h, expected 0x%0h",
                                    m_axis_tdata, want_data));
        end
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      in_count <= in_count + 1;
      if (s_axis_tuser[0] == ACT_QUERY) begin
        blocked_exp_q.push_back(los_blocked(
          int'(s_axis_tdata[FROM_X_LSB +: COORD_W]), int'(s_axis_tdata[FROM_Y_LSB +: COORD_W]),
          int'(s_axis_tdata[TO_X_LSB +: COORD_W]), int'(s_axis_tdata[TO_Y_LSB +: COORD_W])));
      end else begin
        if (int'(s_axis_tdata[CELL_X_LSB +: COORD_W]) < GRID_WIDTH_DEF &&
            int'(s_axis_tdata[CELL_Y_LSB +: COORD_W]) < GRID_HEIGHT_DEF) begin
          occ_map[int'(s_axis_tdata[CELL_Y_LSB +: COORD_W]) * GRID_WIDTH_DEF +
                  int'(s_axis_tdata[CELL_X_LSB +: COORD_W])] = s_axis_tdata[CELL_BLK_B];
        end
      end
    end
  end

  always @(negedge clk_i) begin : beat_sender
    bit        offer;
    bit        quiet;
    los_beat_t b;
    if (rst_ni && (!s_axis_tvalid || s_took)) begin
      offer = 1'b0;
      quiet = in_count >= QUIET_FROM && in_count < QUIET_TO;
      if (beat_q.size() != 0 && !(beat_q[0].wait_idle && blocked_exp_q.size() != 0)) begin
        if (quiet || $urandom_range(99) >= IDLE_PCT) begin
          offer = 1'b1;
          b = beat_q.pop_front();
          s_axis_tdata <= {{(S_TDATA_W - 4 * COORD_W - 2 * COORD_W - 1){1'b0}},
                           b.to_y, b.to_x, b.from_y, b.from_x,
                           b.cell_blocked, b.cell_y, b.cell_x};
          s_axis_tuser <= S_TUSER_W'(b.action);
        end
      end
      s_axis_tvalid <= offer;
    end
  end

  always @(negedge clk_i) begin : result_receiver
    bit quiet;
    quiet = in_count >= QUIET_FROM && in_count < QUIET_TO;
    if (!hold_done && in_count >= HOLD_AT) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet || $urandom_range(99) >= IDLE_PCT;
    end
  end

  initial begin
    int fx;
    int fy;
    for (int i = 0; i < GRID_CELLS; i++) begin
      occ_map[i] = 1'b0;
    end

    // Empty map, then corner cells blocked so that only skipped ends are occupied.
    add_query(0, 0, COORD_MAX, COORD_MAX);
    add_write(0, 0, 1'b1);
    add_write(COORD_MAX, COORD_MAX, 1'b1);
    add_write(COORD_MAX, 0, 1'b1);
    add_write(0, COORD_MAX, 1'b1);
    add_query(0, 0, COORD_MAX, COORD_MAX);
    add_query(COORD_MAX, COORD_MAX, 0, 0);
    add_query(0, 0, COORD_MAX, 0);
    add_query(COORD_MAX, 0, 0, 0);
    add_query(0, COORD_MAX, 0, 0);
    // A blocker in the middle of the diagonal and of a vertical line.
    add_write(32, 32, 1'b1);
    add_query(0, 0, COORD_MAX, COORD_MAX);
    add_query(COORD_MAX, COORD_MAX, 0, 0);
    add_query(32, 0, 32, 40);
    add_query(32, 32, 40, 36);
    add_query(40, 36, 32, 32);
    add_query(5, 5, 5, 5);
    add_query(10, 20, 11, 20);
    add_query(20, 10, 20, 11);
    add_write(32, 32, 1'b0);
    add_query(0, 0, COORD_MAX, COORD_MAX);
    add_query(12, 0, 10, COORD_MAX);

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if ($urandom_range(99) < 45) begin
        add_write($urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                  $urandom_range(99) < 40, i == 0 || i == 1500);
      end else begin
        fx = $urandom_range(COORD_MAX);
        fy = $urandom_range(COORD_MAX);
        if ($urandom_range(99) < 20) begin
          add_query(fx, fy, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                    i == 0 || i == 1500);
        end else begin
          add_query(fx, fy, near_coord(fx, 8), near_coord(fy, 8), i == 0 || i == 1500);
        end
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (beat_q.size() != 0 || s_axis_tvalid) begin
      @(posedge clk_i);
    end
    while (blocked_exp_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("tb_grid_line_of_sight_check_top passed");
    end else begin
      $display("tb_grid_line_of_sight_check_top failed");
    end
    $finish;
  end

endmodule
